/* rtl/itt_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the ID token table.
`timescale 1ns / 1ps
package itt_pkg;

	localparam int SLOTS       = 64;
	localparam int TOKEN_BYTES = 8;
	localparam int SLOT_W      = $clog2(SLOTS);
	localparam int CNT_W       = $clog2(SLOTS + 1);
	localparam int TOKEN_W     = 64;
	localparam int LEN_W       = 4;
	localparam int SLOT_PORT_W = 6;
	localparam int STATUS_W    = 3;
	localparam int ACTION_W    = 2;

	localparam logic [TOKEN_W-1:0] TOKEN_MASK = (TOKEN_BYTES >= 8) ? {TOKEN_W{1'b1}} :
		((TOKEN_W'(1) << (8 * TOKEN_BYTES)) - TOKEN_W'(1));
	localparam logic [7:0] RESERVED_BYTE = 8'hFF;

	typedef enum logic [ACTION_W-1:0] {
		ACT_FIND   = 2'd0,
		ACT_SAVE   = 2'd1,
		ACT_REMOVE = 2'd2,
		ACT_GET    = 2'd3
	} act_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_NOT_FOUND  = 3'd1,
		ST_BAD_LENGTH = 3'd2,
		ST_FULL       = 3'd3,
		ST_EMPTY      = 3'd4,
		ST_BAD_TOKEN  = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_FREE,
		S_GETDATA,
		S_DONE
	} state_t;

	typedef enum logic [3:0] {
		RES_BAD_LEN,
		RES_BAD_TOK,
		RES_HIT,
		RES_NOT_FOUND,
		RES_FULL,
		RES_SAVED,
		RES_REMOVED,
		RES_SLOT_EMPTY,
		RES_GET_OK
	} res_sel_t;

	typedef struct packed {
		logic     cap_in;
		logic     scan_clr;
		logic     scan_step;
		logic     rd_slot;
		logic     set_res;
		res_sel_t res_sel;
		logic     write_new;
		logic     free_step;
		logic     free_done;
		logic     remove_do;
		logic     out_load;
	} itt_cmd_t;

	typedef struct packed {
		act_t             act;
		logic             len_bad;
		logic             tok_bad;
		logic             slot_oob;
		logic             slot_empty;
		logic             hit;
		logic             scan_last;
		logic             full;
		logic             free_stop;
		logic             out_free;
		logic [CNT_W-1:0] next_free;
	} itt_stat_t;

endpackage

/* rtl/id_token_table_top.sv */
// Top level of the ID token table: controller, datapath and checks.
//
//   channel | direction | handshake            | word
//   in      | in        | in_valid / in_ready  | action, token, token_length, slot
//   out     | out       | out_valid / out_ready| result_slot, status, token_out
//
// Find compares one slot per cycle through the single read port of the token memory;
// save adds the free-slot search over the slot flags, one flag per cycle.
// Reset empties every slot at once and clears the free pointer; no clearing pass.
// A result waits in the output register while the next word is accepted;
// the controller holds in its done state while that register is still full.
`timescale 1ns / 1ps
module id_token_table_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [itt_pkg::ACTION_W-1:0]          action,
	input  logic [itt_pkg::TOKEN_W-1:0]           token,
	input  logic [itt_pkg::LEN_W-1:0]             token_length,
	input  logic [itt_pkg::SLOT_PORT_W-1:0]       slot,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [itt_pkg::SLOT_PORT_W-1:0]       result_slot,
	output logic [itt_pkg::STATUS_W-1:0]          status,
	output logic [itt_pkg::TOKEN_W-1:0]           token_out
);
	import itt_pkg::*;

	itt_cmd_t  cmd;
	itt_stat_t stat;
	state_t    state;

	itt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd),
		.state    (state)
	);

	itt_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.action       (action),
		.token        (token),
		.token_length (token_length),
		.slot         (slot),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_slot  (result_slot),
		.status       (status),
		.token_out    (token_out)
	);

`ifndef SYNTHESIS
	a_free_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(stat.next_free) <= 32'(SLOTS))
		else $error("free pointer beyond table");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || out_ready))
		else $error("result loaded over an untaken word");

	a_write_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_new |-> !stat.full)
		else $error("save written into a full table");

	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state == S_DECODE))
		else $error("accepted word not decoded");
`endif

endmodule

/* rtl/itt_dp.sv */
// Datapath: token memory, slot flags, free pointer, scan counter and result registers.
`timescale 1ns / 1ps
module itt_dp (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  itt_pkg::itt_cmd_t                         cmd,
	output itt_pkg::itt_stat_t                        stat,
	input  logic [itt_pkg::ACTION_W-1:0]              action,
	input  logic [itt_pkg::TOKEN_W-1:0]               token,
	input  logic [itt_pkg::LEN_W-1:0]                 token_length,
	input  logic [itt_pkg::SLOT_PORT_W-1:0]           slot,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic [itt_pkg::SLOT_PORT_W-1:0]           result_slot,
	output logic [itt_pkg::STATUS_W-1:0]              status,
	output logic [itt_pkg::TOKEN_W-1:0]               token_out
);
	import itt_pkg::*;

	act_t                   act_q;
	logic [TOKEN_W-1:0]     tok_q;
	logic [LEN_W-1:0]       len_q;
	logic [SLOT_PORT_W-1:0] slot_q;

	logic [TOKEN_W-1:0]     mem [SLOTS];
	logic [TOKEN_W-1:0]     rd_data_s1;
	logic [SLOT_W-1:0]      rd_addr;
	logic [SLOTS-1:0]       used_q;
	logic [CNT_W-1:0]       next_free_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   cmp_valid_s1;
	logic [SLOT_W-1:0]      cmp_addr_s1;
	logic [SLOT_W-1:0]      slot_idx;
	logic [SLOT_W-1:0]      free_idx;

	logic [SLOT_PORT_W-1:0] res_slot_q;
	status_t                res_status_q;
	logic [TOKEN_W-1:0]     res_tok_q;
	logic                   out_valid_q;
	logic [SLOT_PORT_W-1:0] out_slot_q;
	status_t                out_status_q;
	logic [TOKEN_W-1:0]     out_tok_q;

	assign slot_idx = SLOT_W'(slot_q);
	assign free_idx = next_free_q[SLOT_W-1:0];
	assign rd_addr  = cmd.rd_slot ? slot_idx : cnt_q[SLOT_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			act_q  <= act_t'(action);
			tok_q  <= token & TOKEN_MASK;
			len_q  <= token_length;
			slot_q <= slot;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write_new) begin
			mem[free_idx] <= tok_q;
		end
		rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q       <= '0;
			next_free_q  <= '0;
			cnt_q        <= '0;
			cmp_valid_s1 <= 1'b0;
			cmp_addr_s1  <= '0;
		end else begin
			if (cmd.scan_clr) begin
				cnt_q        <= '0;
				cmp_valid_s1 <= 1'b0;
			end else if (cmd.scan_step) begin
				if (32'(cnt_q) < 32'(SLOTS)) begin
					cmp_valid_s1 <= 1'b1;
					cmp_addr_s1  <= cnt_q[SLOT_W-1:0];
					cnt_q        <= cnt_q + CNT_W'(1);
				end else begin
					cmp_valid_s1 <= 1'b0;
				end
			end else if (cmd.write_new) begin
				used_q[free_idx] <= 1'b1;
				cnt_q            <= next_free_q + CNT_W'(1);
			end else if (cmd.free_step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.free_done) begin
				next_free_q <= cnt_q;
			end
			if (cmd.remove_do) begin
				used_q[slot_idx] <= 1'b0;
				if (32'(slot_q) < 32'(next_free_q)) begin
					next_free_q <= CNT_W'(slot_q);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.set_res) begin
			res_tok_q <= '0;
			unique case (cmd.res_sel)
				RES_BAD_LEN: begin
					res_slot_q   <= '0;
					res_status_q <= ST_BAD_LENGTH;
				end
				RES_BAD_TOK: begin
					res_slot_q   <= '0;
					res_status_q <= ST_BAD_TOKEN;
				end
				RES_HIT: begin
					res_slot_q   <= SLOT_PORT_W'(cmp_addr_s1);
					res_status_q <= ST_OK;
				end
				RES_NOT_FOUND: begin
					res_slot_q   <= '0;
					res_status_q <= ST_NOT_FOUND;
				end
				RES_FULL: begin
					res_slot_q   <= '0;
					res_status_q <= ST_FULL;
				end
				RES_SAVED: begin
					res_slot_q   <= SLOT_PORT_W'(next_free_q);
					res_status_q <= ST_OK;
				end
				RES_REMOVED: begin
					res_slot_q   <= slot_q;
					res_status_q <= ST_OK;
				end
				RES_SLOT_EMPTY: begin
					res_slot_q   <= slot_q;
					res_status_q <= ST_EMPTY;
				end
				RES_GET_OK: begin
					res_slot_q   <= slot_q;
					res_status_q <= ST_OK;
					res_tok_q    <= rd_data_s1;
				end
				default: begin
					res_slot_q   <= '0;
					res_status_q <= ST_NOT_FOUND;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_slot_q   <= res_slot_q;
			out_status_q <= res_status_q;
			out_tok_q    <= res_tok_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_slot = out_slot_q;
	assign status      = out_status_q;
	assign token_out   = out_tok_q;

	always_comb begin
		stat            = '0;
		stat.act        = act_q;
		stat.len_bad    = (len_q != LEN_W'(TOKEN_BYTES));
		stat.tok_bad    = (tok_q[7:0] == RESERVED_BYTE);
		stat.slot_oob   = (32'(slot_q) >= 32'(SLOTS));
		stat.slot_empty = !used_q[slot_idx];
		stat.hit        = cmp_valid_s1 && used_q[cmp_addr_s1] && (rd_data_s1 == tok_q);
		stat.scan_last  = cmp_valid_s1 && (32'(cmp_addr_s1) == 32'(SLOTS - 1));
		stat.full       = (32'(next_free_q) >= 32'(SLOTS));
		stat.free_stop  = (32'(cnt_q) >= 32'(SLOTS)) || !used_q[cnt_q[SLOT_W-1:0]];
		stat.out_free   = !out_valid_q || out_ready;
		stat.next_free  = next_free_q;
	end

endmodule

/* rtl/itt_ctrl.sv */
// Controller state machine sequencing decode, slot scan, free search and result hand-off.
`timescale 1ns / 1ps
module itt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  itt_pkg::itt_stat_t  stat,
	output itt_pkg::itt_cmd_t   cmd,
	output itt_pkg::state_t     state
);
	import itt_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				unique case (stat.act)
					ACT_FIND, ACT_SAVE: begin
						if (stat.len_bad || stat.tok_bad) state_d = S_DONE;
						else state_d = S_SCAN;
					end
					ACT_REMOVE: state_d = S_DONE;
					ACT_GET: begin
						if (stat.slot_oob || stat.slot_empty) state_d = S_DONE;
						else state_d = S_GETDATA;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_SCAN: begin
				priority if (stat.hit) state_d = S_DONE;
				else if (stat.scan_last) begin
					if (stat.act == ACT_FIND || stat.full) state_d = S_DONE;
					else state_d = S_FREE;
				end
			end
			S_FREE: begin
				if (stat.free_stop) state_d = S_DONE;
			end
			S_GETDATA: state_d = S_DONE;
			S_DONE: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd     = '0;
		cmd.res_sel = RES_NOT_FOUND;
		unique case (state_q)
			S_IDLE: begin
				cmd.cap_in = in_valid;
			end
			S_DECODE: begin
				unique case (stat.act)
					ACT_FIND, ACT_SAVE: begin
						priority if (stat.len_bad) begin
							cmd.set_res = 1'b1;
							cmd.res_sel = RES_BAD_LEN;
						end else if (stat.tok_bad) begin
							cmd.set_res = 1'b1;
							cmd.res_sel = RES_BAD_TOK;
						end else begin
							cmd.scan_clr = 1'b1;
						end
					end
					ACT_REMOVE: begin
						cmd.set_res = 1'b1;
						if (stat.slot_oob) begin
							cmd.res_sel = RES_SLOT_EMPTY;
						end else begin
							cmd.remove_do = 1'b1;
							cmd.res_sel   = RES_REMOVED;
						end
					end
					ACT_GET: begin
						if (stat.slot_oob || stat.slot_empty) begin
							cmd.set_res = 1'b1;
							cmd.res_sel = RES_SLOT_EMPTY;
						end else begin
							cmd.rd_slot = 1'b1;
						end
					end
					default: cmd.set_res = 1'b1;
				endcase
			end
			S_SCAN: begin
				priority if (stat.hit) begin
					cmd.set_res = 1'b1;
					cmd.res_sel = RES_HIT;
				end else if (stat.scan_last) begin
					cmd.set_res = 1'b1;
					priority if (stat.act == ACT_FIND) begin
						cmd.res_sel = RES_NOT_FOUND;
					end else if (stat.full) begin
						cmd.res_sel = RES_FULL;
					end else begin
						cmd.res_sel   = RES_SAVED;
						cmd.write_new = 1'b1;
					end
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_FREE: begin
				if (stat.free_stop) cmd.free_done = 1'b1;
				else cmd.free_step = 1'b1;
			end
			S_GETDATA: begin
				cmd.set_res = 1'b1;
				cmd.res_sel = RES_GET_OK;
			end
			S_DONE: begin
				cmd.out_load = stat.out_free;
			end
			default: cmd = '0;
		endcase
	end

	assign in_ready = (state_q == S_IDLE);
	assign state    = state_q;

endmodule
